// File: rtl/vpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpt_pkg
// Shared widths, register indexes, pipeline payload and rounding helpers for
// the vertex pose transform and projection pipeline.
// ----------------------------------------------------------------------------
package vpt_pkg;

  localparam int NUM_W   = 60;
  localparam int DIV_LAT = NUM_W + 1;

  localparam logic [7:0] REG_ROT_0_3  = 8'd0;
  localparam logic [7:0] REG_ROT_4_7  = 8'd1;
  localparam logic [7:0] REG_ROT_8    = 8'd2;
  localparam logic [7:0] REG_TRANS_XY = 8'd3;
  localparam logic [7:0] REG_TRANS_Z  = 8'd4;
  localparam logic [7:0] REG_K_0      = 8'd5;
  localparam logic [7:0] REG_K_1      = 8'd6;
  localparam logic [7:0] REG_K_22     = 8'd7;

  typedef struct packed {
    logic [15:0]      idx;
    logic             gt;
    logic [2:0][31:0] cam;
    logic [2:0][15:0] nrm;
    logic [31:0]      ortho_u;
    logic [31:0]      ortho_v;
    logic             ortho;
    logic             fault;
  } payload_t;

  function automatic logic signed [31:0] rnd_sat32(input logic signed [63:0] x,
                                                   input int s);
    logic signed [63:0] y;
    y = (x + (64'sd1 <<< (s - 1))) >>> s;
    if (y > 64'sd2147483647) return 32'sh7fffffff;
    else if (y < -64'sd2147483648) return 32'sh80000000;
    else return y[31:0];
  endfunction

  function automatic logic signed [15:0] rnd_sat16(input logic signed [63:0] x,
                                                   input int s);
    logic signed [63:0] y;
    y = (x + (64'sd1 <<< (s - 1))) >>> s;
    if (y > 64'sd32767) return 16'sh7fff;
    else if (y < -64'sd32768) return 16'sh8000;
    else return y[15:0];
  endfunction

endpackage

// File: rtl/vpt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpt_div
// Pipelined restoring divider, one quotient bit per stage, with signed
// saturation of the quotient to 32 bits on the last stage.
// ----------------------------------------------------------------------------
module vpt_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [vpt_pkg::NUM_W-1:0]     num_i,
  input  logic [31:0]                   den_i,
  input  logic                          neg_i,
  output logic signed [31:0]            quo_o
);

  localparam int NW = vpt_pkg::NUM_W;

  logic [31:0]   rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] q_r   [NW];
  logic [31:0]   den_r [NW];
  logic          neg_r [NW];

  logic [31:0]   rem_nxt [NW];
  logic [NW-1:0] num_nxt [NW];
  logic [NW-1:0] q_nxt   [NW];
  logic [31:0]   den_nxt [NW];
  logic          neg_nxt [NW];

  logic signed [31:0] quo_r;
  logic signed [31:0] quo_nxt;

  always_comb begin
    logic [31:0]   rem_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] q_in;
    logic [31:0]   den_in;
    logic          neg_in;
    logic [32:0]   trial;
    logic          ge;
    for (int j = 0; j < NW; j++) begin
      if (j == 0) begin
        rem_in = '0;
        num_in = num_i;
        q_in   = '0;
        den_in = den_i;
        neg_in = neg_i;
      end else begin
        rem_in = rem_r[j-1];
        num_in = num_r[j-1];
        q_in   = q_r[j-1];
        den_in = den_r[j-1];
        neg_in = neg_r[j-1];
      end
      trial = {rem_in, num_in[NW-1]};
      ge    = (trial >= {1'b0, den_in});
      rem_nxt[j] = ge ? 32'(trial - {1'b0, den_in}) : trial[31:0];
      num_nxt[j] = {num_in[NW-2:0], 1'b0};
      q_nxt[j]   = {q_in[NW-2:0], ge};
      den_nxt[j] = den_in;
      neg_nxt[j] = neg_in;
    end
  end

  always_comb begin
    logic [NW-1:0] q;
    q = q_r[NW-1];
    if (neg_r[NW-1]) begin
      if (q > NW'(64'h8000_0000)) quo_nxt = 32'sh80000000;
      else quo_nxt = -signed'(q[31:0]);
    end else begin
      if (q > NW'(64'h7fff_ffff)) quo_nxt = 32'sh7fffffff;
      else quo_nxt = signed'(q[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NW; j++) begin
        rem_r[j] <= rem_nxt[j];
        num_r[j] <= num_nxt[j];
        q_r[j]   <= q_nxt[j];
        den_r[j] <= den_nxt[j];
        neg_r[j] <= neg_nxt[j];
      end
      quo_r <= quo_nxt;
    end
  end

  assign quo_o = quo_r;

endmodule

// File: rtl/vertex_pose_transform_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_pose_transform_project
// Rigid transform of a displaced vertex and its normal, then orthographic or
// perspective projection through the intrinsic matrix.
// ----------------------------------------------------------------------------
// Stages: 7 arithmetic stages plus a 60-stage bit-per-stage divider and a
// saturation stage lie between input transaction and result.
// Throughput: one vertex per cycle; the whole pipeline holds while a result
// waits on out_ready.
// Reset: synchronous active-low rst_n clears valid bits and loads the
// pose and intrinsic register defaults.
module vertex_pose_transform_project (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_vertex_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_disp_x,
  input  logic signed [31:0] in_disp_y,
  input  logic signed [31:0] in_disp_z,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  input  logic               in_to_ground_truth,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_index,
  output logic signed [31:0] out_cam_x,
  output logic signed [31:0] out_cam_y,
  output logic signed [31:0] out_cam_z,
  output logic signed [15:0] out_rot_norm_x,
  output logic signed [15:0] out_rot_norm_y,
  output logic signed [15:0] out_rot_norm_z,
  output logic signed [31:0] out_proj_u,
  output logic signed [31:0] out_proj_v,
  output logic               out_ground_truth,
  output logic               out_divide_fault,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int DL = vpt_pkg::DIV_LAT;
  localparam int NW = vpt_pkg::NUM_W;

  logic [63:0] rot03_r, rot47_r, txy_r, k0_r, k1_r;
  logic [15:0] rot8_r, k22_r;
  logic [31:0] tz_r;

  logic signed [15:0] rot [9];
  logic signed [15:0] kk  [9];
  logic signed [31:0] tt  [3];

  logic en;

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic [15:0]          idx1_r, idx2_r, idx3_r, idx4_r, idx5_r, idx6_r;
  logic                 gt1_r, gt2_r, gt3_r, gt4_r, gt5_r, gt6_r;
  logic signed [32:0]   p1_r [3];
  logic signed [15:0]   n1_r [3];
  logic signed [48:0]   pr2_r [9];
  logic signed [31:0]   nr2_r [9];
  logic signed [51:0]   acc3_r [3];
  logic signed [33:0]   nacc3_r [3];
  logic signed [31:0]   cam4_r [3], cam5_r [3], cam6_r [3];
  logic signed [15:0]   nrm4_r [3], nrm5_r [3], nrm6_r [3];
  logic signed [47:0]   kc5_r [9];
  logic signed [49:0]   row6_r [3];

  vpt_pkg::payload_t    pl7_r, pl7_nxt;
  logic [NW-1:0]        numu7_r, numv7_r, numu7_nxt, numv7_nxt;
  logic                 negu7_r, negv7_r, negu7_nxt, negv7_nxt;
  logic [31:0]          den7_r, den7_nxt;

  vpt_pkg::payload_t    dly_r [DL];
  logic [DL-1:0]        vld_r;

  logic signed [31:0]   div_u, div_v;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot03_r <= 64'h0000_0001_0000_0000;
      rot47_r <= 64'h0000_4000_0000_4000;
      rot8_r  <= 16'h4000;
      txy_r   <= '0;
      tz_r    <= '0;
      k0_r    <= 64'd16;
      k1_r    <= 64'd16;
      k22_r   <= 16'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        vpt_pkg::REG_ROT_0_3:  rot03_r <= cfg_data;
        vpt_pkg::REG_ROT_4_7:  rot47_r <= cfg_data;
        vpt_pkg::REG_ROT_8:    rot8_r  <= cfg_data[15:0];
        vpt_pkg::REG_TRANS_XY: txy_r   <= cfg_data;
        vpt_pkg::REG_TRANS_Z:  tz_r    <= cfg_data[31:0];
        vpt_pkg::REG_K_0:      k0_r    <= cfg_data;
        vpt_pkg::REG_K_1:      k1_r    <= cfg_data;
        vpt_pkg::REG_K_22:     k22_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rot[i]   = signed'(rot03_r[16*i +: 16]);
      rot[i+4] = signed'(rot47_r[16*i +: 16]);
      kk[i]    = signed'(k0_r[16*i +: 16]);
      kk[i+4]  = signed'(k1_r[16*i +: 16]);
    end
    rot[8] = signed'(rot8_r);
    kk[8]  = signed'(k22_r);
    tt[0]  = signed'(txy_r[31:0]);
    tt[1]  = signed'(txy_r[63:32]);
    tt[2]  = signed'(tz_r);
  end

  // pipeline control
  assign out_valid = vld_r[DL-1];
  assign en        = out_ready || !out_valid;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      vld_r <= '0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      vld_r <= {vld_r[DL-2:0], v7_r};
    end
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r  <= in_vertex_index;
      gt1_r   <= in_to_ground_truth;
      p1_r[0] <= 33'(in_pos_x) + 33'(in_disp_x);
      p1_r[1] <= 33'(in_pos_y) + 33'(in_disp_y);
      p1_r[2] <= 33'(in_pos_z) + 33'(in_disp_z);
      n1_r[0] <= in_norm_x;
      n1_r[1] <= in_norm_y;
      n1_r[2] <= in_norm_z;

      idx2_r <= idx1_r;
      gt2_r  <= gt1_r;
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          pr2_r[3*i+c] <= p1_r[c] * rot[i+3*c];
          nr2_r[3*i+c] <= n1_r[c] * rot[i+3*c];
        end
      end

      idx3_r <= idx2_r;
      gt3_r  <= gt2_r;
      for (int i = 0; i < 3; i++) begin
        acc3_r[i]  <= 52'(pr2_r[3*i]) + 52'(pr2_r[3*i+1]) + 52'(pr2_r[3*i+2])
                      + (52'(tt[i]) <<< 14);
        nacc3_r[i] <= 34'(nr2_r[3*i]) + 34'(nr2_r[3*i+1]) + 34'(nr2_r[3*i+2]);
      end

      idx4_r <= idx3_r;
      gt4_r  <= gt3_r;
      for (int i = 0; i < 3; i++) begin
        cam4_r[i] <= vpt_pkg::rnd_sat32(64'(acc3_r[i]), 14);
        nrm4_r[i] <= vpt_pkg::rnd_sat16(64'(nacc3_r[i]), 14);
      end

      idx5_r <= idx4_r;
      gt5_r  <= gt4_r;
      for (int i = 0; i < 3; i++) begin
        cam5_r[i] <= cam4_r[i];
        nrm5_r[i] <= nrm4_r[i];
        for (int c = 0; c < 3; c++) begin
          kc5_r[3*i+c] <= kk[3*i+c] * cam4_r[c];
        end
      end

      idx6_r <= idx5_r;
      gt6_r  <= gt5_r;
      for (int i = 0; i < 3; i++) begin
        cam6_r[i] <= cam5_r[i];
        nrm6_r[i] <= nrm5_r[i];
        row6_r[i] <= 50'(kc5_r[3*i]) + 50'(kc5_r[3*i+1]) + 50'(kc5_r[3*i+2]);
      end

      pl7_r   <= pl7_nxt;
      numu7_r <= numu7_nxt;
      numv7_r <= numv7_nxt;
      negu7_r <= negu7_nxt;
      negv7_r <= negv7_nxt;
      den7_r  <= den7_nxt;

      dly_r[0] <= pl7_r;
      for (int j = 1; j < DL; j++) begin
        dly_r[j] <= dly_r[j-1];
      end
    end
  end

  // projection setup
  always_comb begin
    logic signed [31:0] w;
    logic signed [32:0] wabs;
    logic signed [49:0] r0abs, r1abs;
    w     = vpt_pkg::rnd_sat32(64'(row6_r[2]), 4);
    wabs  = w[31] ? -33'(w) : 33'(w);
    r0abs = row6_r[0][49] ? -row6_r[0] : row6_r[0];
    r1abs = row6_r[1][49] ? -row6_r[1] : row6_r[1];

    pl7_nxt.idx     = idx6_r;
    pl7_nxt.gt      = gt6_r;
    for (int i = 0; i < 3; i++) begin
      pl7_nxt.cam[i] = cam6_r[i];
      pl7_nxt.nrm[i] = nrm6_r[i];
    end
    pl7_nxt.ortho_u = vpt_pkg::rnd_sat32(64'(row6_r[0]), 4);
    pl7_nxt.ortho_v = vpt_pkg::rnd_sat32(64'(row6_r[1]), 4);
    pl7_nxt.ortho   = (kk[2] == 16'sd0);
    pl7_nxt.fault   = (kk[2] != 16'sd0) && (w == 32'sd0);

    numu7_nxt = {r0abs[47:0], 12'b0};
    numv7_nxt = {r1abs[47:0], 12'b0};
    negu7_nxt = row6_r[0][49] ^ w[31];
    negv7_nxt = row6_r[1][49] ^ w[31];
    den7_nxt  = (w == 32'sd0) ? 32'd1 : wabs[31:0];
  end

  vpt_div u_div_u (
    .clk   (clk),
    .en    (en),
    .num_i (numu7_r),
    .den_i (den7_r),
    .neg_i (negu7_r),
    .quo_o (div_u)
  );

  vpt_div u_div_v (
    .clk   (clk),
    .en    (en),
    .num_i (numv7_r),
    .den_i (den7_r),
    .neg_i (negv7_r),
    .quo_o (div_v)
  );

  // result
  always_comb begin
    vpt_pkg::payload_t pl;
    pl = dly_r[DL-1];
    out_index        = pl.idx;
    out_ground_truth = pl.gt;
    out_cam_x        = signed'(pl.cam[0]);
    out_cam_y        = signed'(pl.cam[1]);
    out_cam_z        = signed'(pl.cam[2]);
    out_rot_norm_x   = signed'(pl.nrm[0]);
    out_rot_norm_y   = signed'(pl.nrm[1]);
    out_rot_norm_z   = signed'(pl.nrm[2]);
    out_divide_fault = pl.fault;
    if (pl.ortho) begin
      out_proj_u = signed'(pl.ortho_u);
      out_proj_v = signed'(pl.ortho_v);
    end else if (pl.fault) begin
      out_proj_u = '0;
      out_proj_v = '0;
    end else begin
      out_proj_u = div_u;
      out_proj_v = div_v;
    end
  end

endmodule
